### rtl/core/fvdh_pkg.sv
// Shared types and codes for the float vector dedup hash unit.
package fvdh_pkg;

	// Operation codes carried in the kind field.
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	// Code with no operation; it changes nothing and still gives a result.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Result value reported when no stored value applies.
	localparam logic signed [31:0] NO_VALUE = -32'sd1;

	// One result item as it leaves the back end.
	typedef struct packed {
		logic               found;
		logic signed [31:0] value;
		logic               inserted;
		logic               pool_full;
	} res_t;

endpackage

### rtl/core/float_vector_dedup_hash_unit.sv
// Top level of the float vector dedup hash unit.
// Usage: items enter through a queue-style port (push while full is low) and
// results leave through another (take the item on the result ports with pop
// while empty is low). Each add, find or clear item gives exactly one result.
// A front end hashes the key one 32-bit word per cycle; when BUCKET_COUNT is
// not a power of two it adds a reciprocal-multiply remainder step. A
// two-entry queue then hands the item to a back end that reads the bucket head
// and walks the chain one entry per cycle through the registered pool memory.
// The two ends overlap, so the rate is set by the slower of them. A clear
// sweeps the bucket heads, one per cycle; after reset the same sweep runs
// with full held high.
// The key_words register may be written only while the unit is idle.
// When the receiver stalls, the output queue fills, the back end waits with
// its finished result, the operation queue fills behind it and full stays high.
module float_vector_dedup_hash_unit #(
	parameter int BUCKET_COUNT  = 1024,
	parameter int POOL_DEPTH    = 256,
	parameter int MAX_KEY_WORDS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_words_wr,
	input  logic [2:0]         key_words,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [31:0]        key_word0,
	input  logic [31:0]        key_word1,
	input  logic [31:0]        key_word2,
	input  logic [31:0]        key_word3,
	input  logic [30:0]        value_index,
	output logic               empty,
	input  logic               pop,
	output logic               found,
	output logic signed [31:0] result_value,
	output logic               inserted,
	output logic               pool_full
);
	localparam int OPW = 2 + $clog2(MAX_KEY_WORDS + 1) + $clog2(BUCKET_COUNT) + 31
		+ MAX_KEY_WORDS * 32;
	localparam int RW  = $bits(fvdh_pkg::res_t);

	logic [2:0]      key_words_q;
	logic            init_busy;
	logic            op_push;
	logic            op_full;
	logic            op_pop;
	logic            op_empty;
	logic [OPW-1:0]  op_wdata;
	logic [OPW-1:0]  op_rdata;
	logic            res_push;
	logic            res_full;
	fvdh_pkg::res_t  res_in;
	fvdh_pkg::res_t  res_out;
	logic [RW-1:0]   res_rdata;

	// Key length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_words_q <= 3'd3;
		end else if (key_words_wr) begin
			key_words_q <= key_words;
		end
	end

	fvdh_front #(.BUCKET_COUNT(BUCKET_COUNT), .MAX_KEY_WORDS(MAX_KEY_WORDS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.key_word0   (key_word0),
		.key_word1   (key_word1),
		.key_word2   (key_word2),
		.key_word3   (key_word3),
		.value_index (value_index),
		.key_words_q (key_words_q),
		.hold        (init_busy),
		.q_full      (op_full),
		.q_push      (op_push),
		.q_data      (op_wdata)
	);

	fvdh_queue #(.WIDTH(OPW), .DEPTH(2)) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_wdata),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_rdata),
		.empty  (op_empty)
	);

	fvdh_back #(
		.BUCKET_COUNT  (BUCKET_COUNT),
		.POOL_DEPTH    (POOL_DEPTH),
		.MAX_KEY_WORDS (MAX_KEY_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (op_empty),
		.q_pop     (op_pop),
		.q_data    (op_rdata),
		.init_busy (init_busy),
		.rq_full   (res_full),
		.rq_push   (res_push),
		.res       (res_in)
	);

	fvdh_queue #(.WIDTH(RW), .DEPTH(2)) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	// Result fields of the oldest waiting transfer.
	assign res_out      = fvdh_pkg::res_t'(res_rdata);
	assign found        = res_out.found;
	assign result_value = res_out.value;
	assign inserted     = res_out.inserted;
	assign pool_full    = res_out.pool_full;
endmodule

### rtl/core/fvdh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fvdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/fvdh_queue.sv
// Small register queue used between the front and back ends and at the output.
module fvdh_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

### rtl/core/fvdh_front.sv
// Front end: takes items, hashes the key one word a cycle and reduces it to a bucket.
module fvdh_front #(
	parameter int BUCKET_COUNT  = 1024,
	parameter int MAX_KEY_WORDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] key_word0,
	input  logic [31:0] key_word1,
	input  logic [31:0] key_word2,
	input  logic [31:0] key_word3,
	input  logic [30:0] value_index,
	input  logic [2:0]  key_words_q,
	input  logic        hold,
	input  logic        q_full,
	output logic        q_push,
	output logic [2 + $clog2(MAX_KEY_WORDS + 1) + $clog2(BUCKET_COUNT) + 31
		+ MAX_KEY_WORDS * 32 - 1:0] q_data
);
	localparam int  KW      = MAX_KEY_WORDS * 32;
	localparam int  NW      = $clog2(MAX_KEY_WORDS + 1);
	localparam int  BW      = $clog2(BUCKET_COUNT);
	localparam bit  IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
	// Reciprocal of the bucket count, scaled by 2^(32 + BW).
	localparam logic [63:0] RECIP = (64'd1 << (32 + BW)) / 64'(BUCKET_COUNT);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_MOD  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t        state_q;
	logic [1:0]     kind_q;
	logic [NW-1:0]  n_q;
	logic [30:0]    value_q;
	logic [KW-1:0]  key_q;
	logic [KW-1:0]  shift_q;
	logic [NW-1:0]  wcnt_q;
	logic [31:0]    hash_q;
	logic [31:0]    quot_q;
	logic [31:0]    rem_q;
	logic [1:0]     mod_step_q;
	logic [BW-1:0]  bucket_q;

	logic [255:0]   port_key;
	logic [KW-1:0]  key_in;
	logic [NW-1:0]  n_in;
	logic [31:0]    hash_next;
	logic [64:0]    mod_prod;
	logic [31:0]    mod_quot;
	logic [31:0]    mod_rem;
	logic [BW-1:0]  rem_fix;
	logic           accept;

	// Folds one key word into the running hash, low byte first.
	function automatic logic [31:0] hash_word(input logic [31:0] h_in,
		input logic [31:0] word);
		logic [31:0] h;
		logic [7:0]  b;
		h = h_in;
		for (int i = 0; i < 4; i++) begin
			b = word[i*8 +: 8];
			h = (h << 5) + h + {{24{b[7]}}, b};
		end
		return h;
	endfunction

	// Key words beyond the four ports read as zero.
	assign port_key = {128'd0, key_word3, key_word2, key_word1, key_word0};
	assign key_in   = port_key[KW-1:0];

	// Clamp the configured word count into its legal range.
	always_comb begin
		if (key_words_q == 3'd0) begin
			n_in = NW'(1);
		end else if (int'(key_words_q) > MAX_KEY_WORDS) begin
			n_in = NW'(MAX_KEY_WORDS);
		end else begin
			n_in = NW'(key_words_q);
		end
	end

	// Hash step.
	assign hash_next = hash_word(hash_q, shift_q[31:0]);

	// Remainder by reciprocal multiplication: the estimated quotient is at most
	// one too small, so one compare and subtract finishes the reduction.
	assign mod_prod = 65'(hash_q) * 65'(RECIP[32:0]);
	assign mod_quot = 32'(mod_prod >> (32 + BW));
	assign mod_rem  = hash_q - quot_q * 32'(BUCKET_COUNT);
	assign rem_fix  = (rem_q >= 32'(BUCKET_COUNT))
		? BW'(rem_q - 32'(BUCKET_COUNT)) : BW'(rem_q);

	assign full   = (state_q != F_IDLE) || hold;
	assign accept = push && !full;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = {kind_q, n_q, bucket_q, value_q, key_q};

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			n_q     <= n_in;
			value_q <= value_index;
			key_q   <= key_in;
		end
	end

	// Sequencer for hashing and bucket reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			shift_q    <= '0;
			wcnt_q     <= '0;
			hash_q     <= '0;
			quot_q     <= '0;
			rem_q      <= '0;
			mod_step_q <= '0;
			bucket_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						shift_q <= key_in;
						wcnt_q  <= n_in;
						hash_q  <= '0;
						if (kind == fvdh_pkg::KIND_ADD || kind == fvdh_pkg::KIND_FIND) begin
							state_q <= F_HASH;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_HASH: begin
					hash_q  <= hash_next;
					shift_q <= shift_q >> 32;
					wcnt_q  <= wcnt_q - 1'b1;
					if (wcnt_q == NW'(1)) begin
						if (IS_POW2) begin
							bucket_q <= hash_next[BW-1:0];
							state_q  <= F_PUSH;
						end else begin
							mod_step_q <= 2'd0;
							state_q    <= F_MOD;
						end
					end
				end
				F_MOD: begin
					if (mod_step_q == 2'd0) begin
						quot_q     <= mod_quot;
						mod_step_q <= 2'd1;
					end else if (mod_step_q == 2'd1) begin
						rem_q      <= mod_rem;
						mod_step_q <= 2'd2;
					end else begin
						bucket_q <= rem_fix;
						state_q  <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

### rtl/core/fvdh_back.sv
// Back end: walks bucket chains, inserts entries and clears the table.
module fvdh_back #(
	parameter int BUCKET_COUNT  = 1024,
	parameter int POOL_DEPTH    = 256,
	parameter int MAX_KEY_WORDS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  logic [2 + $clog2(MAX_KEY_WORDS + 1) + $clog2(BUCKET_COUNT) + 31
		+ MAX_KEY_WORDS * 32 - 1:0] q_data,
	output logic init_busy,
	input  logic rq_full,
	output logic rq_push,
	output fvdh_pkg::res_t res
);
	localparam int KW  = MAX_KEY_WORDS * 32;
	localparam int NW  = $clog2(MAX_KEY_WORDS + 1);
	localparam int BW  = $clog2(BUCKET_COUNT);
	localparam int PW  = $clog2(POOL_DEPTH);
	localparam int CW  = $clog2(POOL_DEPTH + 1);
	localparam int EW  = PW + 31 + KW;
	localparam int OPW = 2 + NW + BW + 31 + KW;

	typedef enum logic [5:0] {
		B_INIT  = 6'b000001,
		B_IDLE  = 6'b000010,
		B_HEAD  = 6'b000100,
		B_ENTRY = 6'b001000,
		B_MISS  = 6'b010000,
		B_RESP  = 6'b100000
	} bstate_t;

	bstate_t         state_q;
	logic [1:0]      kind_q;
	logic [NW-1:0]   n_q;
	logic [BW-1:0]   bucket_q;
	logic [30:0]     value_q;
	logic [KW-1:0]   key_q;
	logic [PW-1:0]   head_q;
	logic [CW-1:0]   cursor_q;
	logic [BW-1:0]   clr_cnt_q;
	logic            clr_op_q;
	fvdh_pkg::res_t  res_q;

	logic [1:0]      op_kind;
	logic [NW-1:0]   op_n;
	logic [BW-1:0]   op_bucket;
	logic [30:0]     op_value;
	logic [KW-1:0]   op_key;

	logic            head_we;
	logic [BW-1:0]   head_waddr;
	logic [PW-1:0]   head_wdata;
	logic [BW-1:0]   head_raddr;
	logic [PW-1:0]   head_rdata;
	logic            entry_we;
	logic [EW-1:0]   entry_wdata;
	logic [PW-1:0]   entry_raddr;
	logic [EW-1:0]   entry_rdata;
	logic [KW-1:0]   e_key;
	logic [30:0]     e_value;
	logic [PW-1:0]   e_link;
	logic            key_match;
	logic            pool_is_full;
	logic            insert;

	// Unpack the queued operation.
	assign op_key    = q_data[KW-1:0];
	assign op_value  = q_data[KW +: 31];
	assign op_bucket = q_data[KW + 31 +: BW];
	assign op_n      = q_data[KW + 31 + BW +: NW];
	assign op_kind   = q_data[OPW-1 -: 2];

	// Unpack a pool entry.
	assign e_key   = entry_rdata[KW-1:0];
	assign e_value = entry_rdata[KW +: 31];
	assign e_link  = entry_rdata[KW + 31 +: PW];

	// Compare only the words that are in use.
	always_comb begin
		key_match = 1'b1;
		for (int w = 0; w < MAX_KEY_WORDS; w++) begin
			if ((w < int'(n_q)) && (e_key[w*32 +: 32] != key_q[w*32 +: 32])) begin
				key_match = 1'b0;
			end
		end
	end

	assign pool_is_full = (cursor_q == CW'(POOL_DEPTH));
	assign insert       = (state_q == B_MISS) && (kind_q == fvdh_pkg::KIND_ADD)
		&& !pool_is_full;

	// Memory port steering.
	assign head_we     = (state_q == B_INIT) || insert;
	assign head_waddr  = (state_q == B_INIT) ? clr_cnt_q : bucket_q;
	assign head_wdata  = (state_q == B_INIT) ? '0 : cursor_q[PW-1:0];
	assign head_raddr  = (state_q == B_IDLE) ? op_bucket : bucket_q;
	assign entry_we    = insert;
	assign entry_wdata = {head_q, value_q, key_q};

	always_comb begin
		unique case (state_q)
			B_HEAD:  entry_raddr = head_rdata;
			B_ENTRY: entry_raddr = e_link;
			default: entry_raddr = '0;
		endcase
	end

	fvdh_ram #(.WIDTH(PW), .DEPTH(BUCKET_COUNT)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	fvdh_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (cursor_q[PW-1:0]),
		.wdata (entry_wdata),
		.raddr (entry_raddr),
		.rdata (entry_rdata)
	);

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign rq_push   = (state_q == B_RESP);
	assign res       = res_q;
	assign init_busy = (state_q == B_INIT) && !clr_op_q;

	// Operation payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= op_kind;
			n_q      <= op_n;
			bucket_q <= op_bucket;
			value_q  <= op_value;
			key_q    <= op_key;
		end
		if (state_q == B_HEAD) begin
			head_q <= head_rdata;
		end
	end

	// Chain walk and table maintenance sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_INIT;
			cursor_q  <= CW'(1);
			clr_cnt_q <= '0;
			clr_op_q  <= 1'b0;
			res_q     <= '0;
		end else begin
			unique case (state_q)
				B_INIT: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == BW'(BUCKET_COUNT - 1)) begin
						clr_cnt_q <= '0;
						cursor_q  <= CW'(1);
						clr_op_q  <= 1'b0;
						state_q   <= clr_op_q ? B_RESP : B_IDLE;
					end
				end
				B_IDLE: begin
					if (!q_empty) begin
						res_q.found     <= 1'b0;
						res_q.value     <= fvdh_pkg::NO_VALUE;
						res_q.inserted  <= 1'b0;
						res_q.pool_full <= 1'b0;
						if (op_kind == fvdh_pkg::KIND_ADD || op_kind == fvdh_pkg::KIND_FIND) begin
							state_q <= B_HEAD;
						end else if (op_kind == fvdh_pkg::KIND_CLEAR) begin
							clr_op_q <= 1'b1;
							state_q  <= B_INIT;
						end else begin
							state_q <= B_RESP;
						end
					end
				end
				B_HEAD: begin
					state_q <= (head_rdata == '0) ? B_MISS : B_ENTRY;
				end
				B_ENTRY: begin
					if (key_match) begin
						res_q.found <= 1'b1;
						if (kind_q == fvdh_pkg::KIND_FIND) begin
							res_q.value <= $signed({1'b0, e_value});
						end
						state_q <= B_RESP;
					end else if (e_link == '0) begin
						state_q <= B_MISS;
					end
				end
				B_MISS: begin
					if (kind_q == fvdh_pkg::KIND_ADD) begin
						if (pool_is_full) begin
							res_q.pool_full <= 1'b1;
						end else begin
							res_q.inserted <= 1'b1;
							cursor_q       <= cursor_q + 1'b1;
						end
					end
					state_q <= B_RESP;
				end
				B_RESP: begin
					if (!rq_full) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

### dv/fvdh_checker.sv
// Checker for the dedup hash unit: predicts each result and compares it with the DUT.
module fvdh_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_words_wr,
	input  logic [2:0]         key_words,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         kind,
	input  logic [31:0]        key_word0,
	input  logic [31:0]        key_word1,
	input  logic [31:0]        key_word2,
	input  logic [31:0]        key_word3,
	input  logic [30:0]        value_index,
	input  logic               empty,
	input  logic               pop,
	input  logic               found,
	input  logic signed [31:0] result_value,
	input  logic               inserted,
	input  logic               pool_full,
	output int                 fail_count,
	output int                 pending_count
);
	localparam int BUCKETS = 1024;
	localparam int POOL = 256;

	// Private copy of the table state.
	logic [2:0]      len_reg;
	int              head_tab [BUCKETS];
	logic [31:0]     slot_key [POOL][4];
	logic [30:0]     slot_val [POOL];
	int              slot_next [POOL];
	int              cursor;
	fvdh_pkg::res_t  expected_results [$];

	function automatic int word_total();
		if (len_reg < 3'd1) return 1;
		if (len_reg > 3'd4) return 4;
		return int'(len_reg);
	endfunction

	function automatic int bucket_of(logic [31:0] k [4], int n);
		logic [31:0] h;
		logic [7:0]  b;
		h = 0;
		for (int w = 0; w < n; w++)
			for (int i = 0; i < 4; i++) begin
				b = k[w][8*i +: 8];
				h = h * 32'd33 + {{24{b[7]}}, b};
			end
		return h % BUCKETS;
	endfunction

	function automatic int find_slot(int bkt, logic [31:0] k [4], int n);
		int s;
		int steps;
		bit same;
		s = head_tab[bkt];
		steps = 0;
		while (s != 0 && s < POOL && steps < POOL) begin
			same = 1;
			for (int i = 0; i < n; i++)
				if (slot_key[s][i] != k[i]) same = 0;
			if (same) return s;
			s = slot_next[s];
			steps++;
		end
		return 0;
	endfunction

	// Work out the result of one accepted item and update the table copy.
	function automatic fvdh_pkg::res_t predict_lookup(logic [1:0] op, logic [31:0] k [4],
			logic [30:0] v);
		fvdh_pkg::res_t r;
		int n, bkt, s;
		r = '{found: 0, value: fvdh_pkg::NO_VALUE, inserted: 0, pool_full: 0};
		n = word_total();
		if (op == fvdh_pkg::KIND_ADD) begin
			bkt = bucket_of(k, n);
			if (find_slot(bkt, k, n) != 0) r.found = 1;
			else if (cursor >= POOL) r.pool_full = 1;
			else begin
				slot_key[cursor] = k;
				slot_val[cursor] = v;
				slot_next[cursor] = head_tab[bkt];
				head_tab[bkt] = cursor;
				cursor++;
				r.inserted = 1;
			end
		end else if (op == fvdh_pkg::KIND_FIND) begin
			s = find_slot(bucket_of(k, n), k, n);
			if (s != 0) begin
				r.found = 1;
				r.value = {1'b0, slot_val[s]};
			end
		end else if (op == fvdh_pkg::KIND_CLEAR) begin
			foreach (head_tab[i]) head_tab[i] = 0;
			cursor = 1;
		end
		return r;
	endfunction

	assign pending_count = expected_results.size();

	// Watch both channels at each edge.
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] k [4];
		fvdh_pkg::res_t exp_r;
		if (!arst_n) begin
			len_reg = 3'd3;
			foreach (head_tab[i]) head_tab[i] = 0;
			cursor = 1;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation waiting");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (found !== exp_r.found) begin
						$error("found: expected %0d actual %0d", exp_r.found, found);
						fail_count++;
					end
					if (result_value !== exp_r.value) begin
						$error("result_value: expected %0d actual %0d",
							exp_r.value, result_value);
						fail_count++;
					end
					if (inserted !== exp_r.inserted) begin
						$error("inserted: expected %0d actual %0d",
							exp_r.inserted, inserted);
						fail_count++;
					end
					if (pool_full !== exp_r.pool_full) begin
						$error("pool_full: expected %0d actual %0d",
							exp_r.pool_full, pool_full);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				k[0] = key_word0;
				k[1] = key_word1;
				k[2] = key_word2;
				k[3] = key_word3;
				expected_results.push_back(predict_lookup(kind, k, value_index));
			end
			if (key_words_wr) len_reg = key_words;
		end
	end
endmodule

### dv/testbench.sv
// Top of the dedup hash unit testbench: stimulus, configuration phases and verdict.
module testbench;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               key_words_wr = 0;
	logic [2:0]         key_words = 3'd3;
	logic               push = 0;
	logic               full;
	logic [1:0]         kind = fvdh_pkg::KIND_FIND;
	logic [31:0]        key_word0 = 0, key_word1 = 0, key_word2 = 0, key_word3 = 0;
	logic [30:0]        value_index = 0;
	logic               empty;
	logic               pop = 0;
	logic               found, inserted, pool_full;
	logic signed [31:0] result_value;
	int                 fail_count, pending_count;
	int                 cycle_count = 0;
	int                 item_count = 0;
	int                 pop_gap = 0;
	logic [31:0]        key_pool [16][4];

	always #5 clk = ~clk;

	float_vector_dedup_hash_unit uut (.*);

	fvdh_checker checker_i (.*);

	// Run limit: generous against reset sweep, clears and stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Receiver: pops with random stalls of random length, a few of them long.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 0;
			pop_gap <= 0;
		end else if (pop_gap > 0) begin
			pop <= 0;
			pop_gap <= pop_gap - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			pop <= 0;
			pop_gap <= gap_len();
		end else begin
			pop <= 1;
		end
	end

	// One item transfer; push stays high across back-to-back items.
	task automatic send_item(logic [1:0] op, logic [31:0] w0, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3, logic [30:0] v);
		int g;
		g = gap_len();
		if (g > 0) begin
			push <= 0;
			repeat (g) @(posedge clk);
		end
		push <= 1;
		kind <= op;
		key_word0 <= w0;
		key_word1 <= w1;
		key_word2 <= w2;
		key_word3 <= w3;
		value_index <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		item_count++;
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_len(logic [2:0] n);
		drain();
		key_words_wr <= 1;
		key_words <= n;
		@(posedge clk);
		key_words_wr <= 0;
	endtask

	// Random item: mostly adds and finds of recycled keys.
	task automatic random_item();
		int r, p;
		logic [31:0] w [4];
		r = $urandom_range(0, 99);
		p = $urandom_range(0, 15);
		for (int i = 0; i < 4; i++)
			w[i] = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[p][i];
		if (r < 2)
			send_item(fvdh_pkg::KIND_CLEAR, w[0], w[1], w[2], w[3], 31'($urandom));
		else if (r < 4)
			send_item(fvdh_pkg::KIND_UNUSED, w[0], w[1], w[2], w[3], 31'($urandom));
		else if (r < 50)
			send_item(fvdh_pkg::KIND_ADD, w[0], w[1], w[2], w[3], 31'($urandom));
		else
			send_item(fvdh_pkg::KIND_FIND, w[0], w[1], w[2], w[3], 31'($urandom));
	endtask

	initial begin
		foreach (key_pool[i, j]) key_pool[i][j] = $urandom;
		key_pool[0] = '{0, 0, 0, 0};
		key_pool[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, all operations, duplicates, unused kind, clear.
		send_item(fvdh_pkg::KIND_FIND, 0, 0, 0, 0, 0);
		send_item(fvdh_pkg::KIND_ADD, 0, 0, 0, 0, 31'h7FFF_FFFF);
		send_item(fvdh_pkg::KIND_ADD, 0, 0, 0, 0, 5);
		send_item(fvdh_pkg::KIND_FIND, 0, 0, 0, 0, 0);
		send_item(fvdh_pkg::KIND_ADD, '1, '1, '1, '1, 0);
		send_item(fvdh_pkg::KIND_FIND, '1, '1, '1, 32'h1234, 0);
		send_item(fvdh_pkg::KIND_FIND, '1, '1, '1, '1, 0);
		send_item(fvdh_pkg::KIND_ADD, 32'h8080_8080, 32'h7F7F_7F7F, 1, 2, 77);
		send_item(fvdh_pkg::KIND_FIND, 32'h8080_8080, 32'h7F7F_7F7F, 1, 2, 0);
		send_item(fvdh_pkg::KIND_UNUSED, '1, '1, '1, '1, '1);
		send_item(fvdh_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
		send_item(fvdh_pkg::KIND_FIND, 0, 0, 0, 0, 0);
		send_item(fvdh_pkg::KIND_ADD, 32'h3F80_0000, 0, 0, 0, 9);
		set_len(3'd1);
		send_item(fvdh_pkg::KIND_FIND, 32'h3F80_0000, 5, 6, 7, 0);
		send_item(fvdh_pkg::KIND_ADD, 32'h3F80_0000, 8, 8, 8, 3);
		set_len(3'd4);
		send_item(fvdh_pkg::KIND_ADD, 32'h3F80_0000, 8, 8, 8, 4);
		set_len(3'd0);
		send_item(fvdh_pkg::KIND_FIND, 32'h3F80_0000, 1, 1, 1, 0);
		set_len(3'd7);
		send_item(fvdh_pkg::KIND_FIND, 32'h3F80_0000, 8, 8, 8, 0);

		// Fill the pool past its depth to reach the full case.
		send_item(fvdh_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
		for (int i = 0; i < 260; i++)
			send_item(fvdh_pkg::KIND_ADD, i, $urandom, $urandom, $urandom, 31'($urandom));
		send_item(fvdh_pkg::KIND_FIND, 3, 0, 0, 0, 0);
		send_item(fvdh_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);

		// Random phases across key lengths.
		for (int ph = 0; ph < 6; ph++) begin
			set_len(ph == 0 ? 3'd1 : ph == 1 ? 3'd4 : 3'($urandom_range(0, 7)));
			for (int i = 0; i < 55; i++) random_item();
		end

		drain();
		$display("Covered %0d items: adds, finds, clears, unused kind, pool full,",
			item_count);
		$display("key lengths 0 to 7, with random stalls on both sides.");
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
